// ----- rtl/core/code128b_symbol_encoder_top_defines.svh -----
// Assertion helpers for the checker file cbe_checker.sv.
`ifndef CODE128B_SYMBOL_ENCODER_TOP_DEFINES_SVH
`define CODE128B_SYMBOL_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define CBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("segment check failed");

// Next-cycle implication, reset masks the check.
`define CBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("segment sequence check failed");

`endif

// ----- rtl/core/cbe_pkg.sv -----
package cbe_pkg;

	localparam logic [6:0]  START_B_VALUE = 7'd104;
	localparam logic [6:0]  CHECK_MOD     = 7'd103;
	localparam logic [6:0]  SET_B_OFFSET  = 7'd32;
	localparam logic [7:0]  CHAR_MODULES  = 8'd11;
	localparam logic [7:0]  STOP_MODULES  = 8'd13;
	localparam logic [12:0] STOP_PATTERN  = 13'h18EB;
	localparam logic [7:0]  QUIET_RESET   = 8'd10;

	localparam logic [2:0] KIND_QUIET = 3'd0;
	localparam logic [2:0] KIND_START = 3'd1;
	localparam logic [2:0] KIND_DATA  = 3'd2;
	localparam logic [2:0] KIND_CSUM  = 3'd3;
	localparam logic [2:0] KIND_STOP  = 3'd4;

	// One classified character waiting for the segment sequencer.
	typedef struct packed {
		logic       first;
		logic       last;
		logic       bad;
		logic [6:0] value;
		logic [6:0] csum;
	} cbe_entry_t;

	typedef struct packed {
		logic       valid;
		cbe_entry_t entry;
	} cbe_slot_t;

	// Code 128 symbol patterns, 11 modules, most significant first.
	function automatic logic [10:0] cbe_pattern(input logic [6:0] v);
		logic [10:0] p;
		case (v)
			7'd0:   p = 11'h6CC; 7'd1:   p = 11'h66C; 7'd2:   p = 11'h666; 7'd3:   p = 11'h498;
			7'd4:   p = 11'h48C; 7'd5:   p = 11'h44C; 7'd6:   p = 11'h4C8; 7'd7:   p = 11'h4C4;
			7'd8:   p = 11'h464; 7'd9:   p = 11'h648; 7'd10:  p = 11'h644; 7'd11:  p = 11'h624;
			7'd12:  p = 11'h59C; 7'd13:  p = 11'h4DC; 7'd14:  p = 11'h4CE; 7'd15:  p = 11'h5CC;
			7'd16:  p = 11'h4EC; 7'd17:  p = 11'h4E6; 7'd18:  p = 11'h672; 7'd19:  p = 11'h65C;
			7'd20:  p = 11'h64E; 7'd21:  p = 11'h6E4; 7'd22:  p = 11'h674; 7'd23:  p = 11'h76E;
			7'd24:  p = 11'h74C; 7'd25:  p = 11'h72C; 7'd26:  p = 11'h726; 7'd27:  p = 11'h764;
			7'd28:  p = 11'h734; 7'd29:  p = 11'h732; 7'd30:  p = 11'h6D8; 7'd31:  p = 11'h6C6;
			7'd32:  p = 11'h636; 7'd33:  p = 11'h518; 7'd34:  p = 11'h458; 7'd35:  p = 11'h446;
			7'd36:  p = 11'h588; 7'd37:  p = 11'h468; 7'd38:  p = 11'h462; 7'd39:  p = 11'h688;
			7'd40:  p = 11'h628; 7'd41:  p = 11'h622; 7'd42:  p = 11'h5B8; 7'd43:  p = 11'h58E;
			7'd44:  p = 11'h46E; 7'd45:  p = 11'h5D8; 7'd46:  p = 11'h5C6; 7'd47:  p = 11'h476;
			7'd48:  p = 11'h776; 7'd49:  p = 11'h68E; 7'd50:  p = 11'h62E; 7'd51:  p = 11'h6E8;
			7'd52:  p = 11'h6E2; 7'd53:  p = 11'h6EE; 7'd54:  p = 11'h758; 7'd55:  p = 11'h746;
			7'd56:  p = 11'h716; 7'd57:  p = 11'h768; 7'd58:  p = 11'h762; 7'd59:  p = 11'h71A;
			7'd60:  p = 11'h77A; 7'd61:  p = 11'h642; 7'd62:  p = 11'h78A; 7'd63:  p = 11'h530;
			7'd64:  p = 11'h50C; 7'd65:  p = 11'h4B0; 7'd66:  p = 11'h486; 7'd67:  p = 11'h42C;
			7'd68:  p = 11'h426; 7'd69:  p = 11'h590; 7'd70:  p = 11'h584; 7'd71:  p = 11'h4D0;
			7'd72:  p = 11'h4C2; 7'd73:  p = 11'h434; 7'd74:  p = 11'h432; 7'd75:  p = 11'h612;
			7'd76:  p = 11'h650; 7'd77:  p = 11'h7BA; 7'd78:  p = 11'h614; 7'd79:  p = 11'h47A;
			7'd80:  p = 11'h53C; 7'd81:  p = 11'h4BC; 7'd82:  p = 11'h49E; 7'd83:  p = 11'h5E4;
			7'd84:  p = 11'h4F4; 7'd85:  p = 11'h4F2; 7'd86:  p = 11'h7A4; 7'd87:  p = 11'h794;
			7'd88:  p = 11'h792; 7'd89:  p = 11'h6DE; 7'd90:  p = 11'h6F6; 7'd91:  p = 11'h7B6;
			7'd92:  p = 11'h578; 7'd93:  p = 11'h51E; 7'd94:  p = 11'h45E; 7'd95:  p = 11'h5E8;
			7'd96:  p = 11'h5E2; 7'd97:  p = 11'h7A8; 7'd98:  p = 11'h7A2; 7'd99:  p = 11'h5DE;
			7'd100: p = 11'h5EE; 7'd101: p = 11'h75E; 7'd102: p = 11'h7AE; 7'd103: p = 11'h684;
			7'd104: p = 11'h690; 7'd105: p = 11'h69C;
			default: p = 11'h000;
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/core/cbe_ifs.sv -----
interface cbe_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic       is_last;
	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface cbe_seg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  segment_kind;
	logic [12:0] module_pattern;
	logic [7:0]  module_count;
	logic        bad_char;
	logic        run_end;
	modport source (output valid, output segment_kind, output module_pattern,
		output module_count, output bad_char, output run_end, input ready);
	modport sink   (input valid, input segment_kind, input module_pattern,
		input module_count, input bad_char, input run_end, output ready);
endinterface

interface cbe_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] quiet_zone_modules;
	modport source (output valid, output quiet_zone_modules, input ready);
	modport sink   (input valid, input quiet_zone_modules, output ready);
endinterface

// ----- rtl/core/cbe_front.sv -----
module cbe_front (
	input  logic            clk,
	input  logic            arst_n,
	cbe_char_if.sink        msg_in,
	input  logic            full,
	output cbe_pkg::cbe_slot_t push
);

	logic        vld_s1;
	logic        first_s1;
	logic        last_s1;
	logic        bad_s1;
	logic [6:0]  value_s1;
	logic [13:0] prod_s1;

	logic        in_msg_q;
	logic [6:0]  pos_q;
	logic [6:0]  acc_q;

	logic        accept;
	logic        push_ok;
	logic        bad;
	logic [6:0]  value;
	logic [6:0]  acc_new;

	// Fold a sum below 9856 to its residue mod 103 (128 = 25 mod 103).
	function automatic logic [6:0] mod103(input logic [13:0] x);
		logic [10:0] y;
		logic [8:0]  z;
		logic [7:0]  w;
		y = 11'(x[13:7]) * 11'd25 + 11'(x[6:0]);
		z = 9'(y[10:7]) * 9'd25 + 9'(y[6:0]);
		w = 8'(z[8:7]) * 8'd25 + 8'(z[6:0]);
		if (w >= 8'(cbe_pkg::CHECK_MOD)) begin
			w = w - 8'(cbe_pkg::CHECK_MOD);
		end
		return w[6:0];
	endfunction

	assign push_ok      = vld_s1 && !full;
	assign msg_in.ready = !vld_s1 || !full;
	assign accept       = msg_in.valid && msg_in.ready;

	// Codes below the set B range encode as space.
	assign bad   = (msg_in.char_code < cbe_pkg::SET_B_OFFSET);
	assign value = bad ? 7'd0 : (msg_in.char_code - cbe_pkg::SET_B_OFFSET);

	assign acc_new = mod103(14'(acc_q) + prod_s1);

	assign push.valid       = vld_s1;
	assign push.entry.first = first_s1;
	assign push.entry.last  = last_s1;
	assign push.entry.bad   = bad_s1;
	assign push.entry.value = value_s1;
	assign push.entry.csum  = acc_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			in_msg_q <= 1'b0;
			pos_q    <= 7'd1;
			acc_q    <= 7'd1;
		end else begin
			if (accept) begin
				vld_s1   <= 1'b1;
				in_msg_q <= !msg_in.is_last;
				if (msg_in.is_last) begin
					pos_q <= 7'd1;
				end else if (pos_q == cbe_pkg::CHECK_MOD - 7'd1) begin
					pos_q <= 7'd0;
				end else begin
					pos_q <= pos_q + 7'd1;
				end
			end else if (push_ok) begin
				vld_s1 <= 1'b0;
			end
			if (push_ok) begin
				acc_q <= last_s1 ? 7'd1 : acc_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1 <= !in_msg_q;
			last_s1  <= msg_in.is_last;
			bad_s1   <= bad;
			value_s1 <= value;
			prod_s1  <= 14'(value) * 14'(pos_q);
		end
	end

endmodule

// ----- rtl/core/cbe_queue.sv -----
module cbe_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cbe_pkg::cbe_slot_t push,
	output logic               full,
	output cbe_pkg::cbe_slot_t head,
	input  logic               pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cbe_pkg::cbe_entry_t slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.entry = slot_q[rd_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push.entry;
		end
	end

endmodule

// ----- rtl/core/cbe_back.sv -----
module cbe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         quiet_zone_modules,
	input  cbe_pkg::cbe_slot_t head,
	output logic               pop,
	cbe_seg_if.source          seg_out
);

	localparam logic [2:0] ST_LEAD  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_DATA  = 3'd2;
	localparam logic [2:0] ST_CSUM  = 3'd3;
	localparam logic [2:0] ST_STOP  = 3'd4;
	localparam logic [2:0] ST_TRAIL = 3'd5;

	logic                busy_q;
	logic [2:0]          step_q;
	cbe_pkg::cbe_entry_t cur_q;

	logic        out_vld_q;
	logic [2:0]  kind_q;
	logic [12:0] pat_q;
	logic [7:0]  count_q;
	logic        bad_q;
	logic        end_q;

	logic        adv;
	logic        seg_final;
	logic [2:0]  step_nxt;
	logic [2:0]  kind;
	logic [6:0]  idx;
	logic [12:0] pat;
	logic [7:0]  count;
	logic        bad;

	assign adv = busy_q && (!out_vld_q || seg_out.ready);
	assign pop = head.valid && (!busy_q || (adv && seg_final));

	always_comb begin
		kind      = cbe_pkg::KIND_QUIET;
		idx       = cur_q.value;
		count     = cbe_pkg::CHAR_MODULES;
		bad       = 1'b0;
		seg_final = 1'b0;
		step_nxt  = ST_LEAD;
		case (step_q)
			ST_LEAD: begin
				count    = quiet_zone_modules;
				step_nxt = ST_START;
			end
			ST_START: begin
				kind     = cbe_pkg::KIND_START;
				idx      = cbe_pkg::START_B_VALUE;
				step_nxt = ST_DATA;
			end
			ST_DATA: begin
				kind      = cbe_pkg::KIND_DATA;
				bad       = cur_q.bad;
				seg_final = !cur_q.last;
				step_nxt  = ST_CSUM;
			end
			ST_CSUM: begin
				kind     = cbe_pkg::KIND_CSUM;
				idx      = cur_q.csum;
				step_nxt = ST_STOP;
			end
			ST_STOP: begin
				kind     = cbe_pkg::KIND_STOP;
				count    = cbe_pkg::STOP_MODULES;
				step_nxt = ST_TRAIL;
			end
			ST_TRAIL: begin
				count     = quiet_zone_modules;
				seg_final = 1'b1;
			end
			default: begin
				seg_final = 1'b1;
			end
		endcase
		if (kind == cbe_pkg::KIND_QUIET) begin
			pat = '0;
		end else if (kind == cbe_pkg::KIND_STOP) begin
			pat = cbe_pkg::STOP_PATTERN;
		end else begin
			pat = 13'(cbe_pkg::cbe_pattern(idx));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= ST_LEAD;
			out_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= head.entry.first ? ST_LEAD : ST_DATA;
			end else if (adv && seg_final) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				step_q <= step_nxt;
			end
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (seg_out.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.entry;
		end
		if (adv) begin
			kind_q  <= kind;
			pat_q   <= pat;
			count_q <= count;
			bad_q   <= bad;
			end_q   <= seg_final;
		end
	end

	assign seg_out.valid          = out_vld_q;
	assign seg_out.segment_kind   = kind_q;
	assign seg_out.module_pattern = pat_q;
	assign seg_out.module_count   = count_q;
	assign seg_out.bad_char       = bad_q;
	assign seg_out.run_end        = end_q;

endmodule

// ----- rtl/core/code128b_symbol_encoder_top.sv -----
// Path: front register, queue, back character register, segment output register.
// Throughput: the input takes one character per cycle until the queue fills; the segment
// sequencer emits one segment per cycle while the receiver is ready; a character makes
// one segment mid-message, three as the first, four as the last and six as a one-character
// message. Reset (arst_n low, asynchronous): queue empty, no symbol open, checksum 1,
// position 1, quiet zone 10 modules.
module code128b_symbol_encoder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	cbe_char_if.sink  msg_in,
	cbe_cfg_if.sink   cfg,
	cbe_seg_if.source seg_out
);

	// Quiet zone length; user rule: written only while the block is idle, not enforced.
	logic [7:0] quiet_q;

	// Front to queue: one classified character with its running checksum.
	cbe_pkg::cbe_slot_t push;
	// Queue to back: the oldest waiting character.
	cbe_pkg::cbe_slot_t head;
	logic               full;
	logic               pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_q <= cbe_pkg::QUIET_RESET;
		end else if (cfg.valid) begin
			quiet_q <= cfg.quiet_zone_modules;
		end
	end

	// Front: classify the character, track message start and position,
	// advance the weighted checksum (multiply in one stage, fold mod 103 on push).
	cbe_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.msg_in (msg_in),
		.full   (full),
		.push   (push)
	);

	// Short queue: lets the front keep taking characters while the back is
	// still spelling out start, checksum, stop and quiet zones.
	cbe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.head   (head),
		.pop    (pop)
	);

	// Back: walk the segments of each character into the output register.
	cbe_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.quiet_zone_modules (quiet_q),
		.head               (head),
		.pop                (pop),
		.seg_out            (seg_out)
	);

endmodule

// ----- rtl/core/cbe_checker.sv -----
`include "code128b_symbol_encoder_top_defines.svh"

module cbe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [2:0]  segment_kind,
	input logic [12:0] module_pattern,
	input logic [7:0]  module_count,
	input logic        bad_char,
	input logic        run_end
);

	logic beat;
	assign beat = valid && ready;

	// Quiet zones carry no bars.
	`CBE_ASSERT_NOW(a_quiet_blank, clk, arst_n,
		valid && segment_kind == cbe_pkg::KIND_QUIET, module_pattern == '0)

	// Stop closes with the fixed pattern and is never the final segment.
	`CBE_ASSERT_NOW(a_stop_shape, clk, arst_n,
		valid && segment_kind == cbe_pkg::KIND_STOP,
		module_pattern == cbe_pkg::STOP_PATTERN && module_count == cbe_pkg::STOP_MODULES
		&& !run_end)

	// Only data segments flag a bad character.
	`CBE_ASSERT_NOW(a_bad_on_data, clk, arst_n,
		valid && bad_char, segment_kind == cbe_pkg::KIND_DATA)

	// Start is always followed by the first data segment.
	`CBE_ASSERT_NEXT(a_start_then_data, clk, arst_n,
		beat && segment_kind == cbe_pkg::KIND_START,
		!valid || segment_kind == cbe_pkg::KIND_DATA)

	// Checksum is always followed by stop.
	`CBE_ASSERT_NEXT(a_csum_then_stop, clk, arst_n,
		beat && segment_kind == cbe_pkg::KIND_CSUM,
		!valid || segment_kind == cbe_pkg::KIND_STOP)

endmodule

bind code128b_symbol_encoder_top cbe_checker u_cbe_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.valid          (seg_out.valid),
	.ready          (seg_out.ready),
	.segment_kind   (seg_out.segment_kind),
	.module_pattern (seg_out.module_pattern),
	.module_count   (seg_out.module_count),
	.bad_char       (seg_out.bad_char),
	.run_end        (seg_out.run_end)
);

// ----- bench/code128b_symbol_encoder_top_tb.sv -----
module code128b_symbol_encoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any beat on any channel before the run is declared hung.
	// The slowest correct stretch is a sender gap or a receiver stall, so this is far
	// beyond any legal pause.
	localparam int HANG_LIMIT = 2000;
	// Cycles to keep watching the output after the last expected beat.
	localparam int DRAIN_CYCLES = 16;
	localparam int PRINT_CAP = 40;

	// Standard Code 128 symbol patterns indexed by symbol value.
	localparam logic [10:0] SYM_TABLE [0:105] = '{
		11'h6CC, 11'h66C, 11'h666, 11'h498, 11'h48C, 11'h44C, 11'h4C8, 11'h4C4,
		11'h464, 11'h648, 11'h644, 11'h624, 11'h59C, 11'h4DC, 11'h4CE, 11'h5CC,
		11'h4EC, 11'h4E6, 11'h672, 11'h65C, 11'h64E, 11'h6E4, 11'h674, 11'h76E,
		11'h74C, 11'h72C, 11'h726, 11'h764, 11'h734, 11'h732, 11'h6D8, 11'h6C6,
		11'h636, 11'h518, 11'h458, 11'h446, 11'h588, 11'h468, 11'h462, 11'h688,
		11'h628, 11'h622, 11'h5B8, 11'h58E, 11'h46E, 11'h5D8, 11'h5C6, 11'h476,
		11'h776, 11'h68E, 11'h62E, 11'h6E8, 11'h6E2, 11'h6EE, 11'h758, 11'h746,
		11'h716, 11'h768, 11'h762, 11'h71A, 11'h77A, 11'h642, 11'h78A, 11'h530,
		11'h50C, 11'h4B0, 11'h486, 11'h42C, 11'h426, 11'h590, 11'h584, 11'h4D0,
		11'h4C2, 11'h434, 11'h432, 11'h612, 11'h650, 11'h7BA, 11'h614, 11'h47A,
		11'h53C, 11'h4BC, 11'h49E, 11'h5E4, 11'h4F4, 11'h4F2, 11'h7A4, 11'h794,
		11'h792, 11'h6DE, 11'h6F6, 11'h7B6, 11'h578, 11'h51E, 11'h45E, 11'h5E8,
		11'h5E2, 11'h7A8, 11'h7A2, 11'h5DE, 11'h5EE, 11'h75E, 11'h7AE, 11'h684,
		11'h690, 11'h69C
	};

	typedef struct {
		logic [6:0] code;
		logic       last;
	} char_beat_t;

	typedef struct {
		logic [2:0]  kind;
		logic [12:0] pattern;
		logic [7:0]  count;
		logic        bad;
		logic        run_end;
	} segment_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Testbench-side copies of every block input, known from time zero.
	logic       char_valid  = 1'b0;
	logic [6:0] char_code_q = '0;
	logic       char_last_q = 1'b0;
	logic       seg_ready   = 1'b0;
	logic       cfg_valid   = 1'b0;
	logic [7:0] cfg_quiet_q = '0;

	cbe_char_if msg_in ();
	cbe_seg_if  seg_out ();
	cbe_cfg_if  cfg ();

	assign msg_in.valid              = char_valid;
	assign msg_in.char_code          = char_code_q;
	assign msg_in.is_last            = char_last_q;
	assign seg_out.ready             = seg_ready;
	assign cfg.valid                 = cfg_valid;
	assign cfg.quiet_zone_modules    = cfg_quiet_q;

	code128b_symbol_encoder_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg_in  (msg_in),
		.cfg     (cfg),
		.seg_out (seg_out)
	);

	always #4 clk = ~clk;

	// Characters waiting to be offered, and segments the encoder owes us.
	char_beat_t char_queue [$];
	segment_t   seg_expect [$];

	// Shadow of the encoder state and its one register.
	logic       msg_open  = 1'b0;
	logic [6:0] csum_acc  = 7'd1;
	logic [6:0] char_pos  = 7'd1;
	logic [7:0] quiet_len = cbe_pkg::QUIET_RESET;

	// Pacing knobs, set per phase by the sequence below.
	logic sender_gaps = 1'b0;
	logic rx_stalls   = 1'b0;

	int error_count  = 0;
	int chars_sent   = 0;
	int bad_sent     = 0;
	int msgs_done    = 0;
	int segs_checked = 0;
	int cfg_writes   = 0;
	int longest_msg  = 0;
	int cur_msg_len  = 0;

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("[%0t] segment %0d: %s got 'h%0h, want 'h%0h",
				$realtime, segs_checked, what, got_v, want_v);
	endtask

	function automatic segment_t make_seg(input logic [2:0] kind, input logic [12:0] pattern,
		input logic [7:0] count, input logic bad, input logic run_end);
		segment_t s;
		s.kind    = kind;
		s.pattern = pattern;
		s.count   = count;
		s.bad     = bad;
		s.run_end = run_end;
		return s;
	endfunction

	// Append one owed segment at the tail of the expectation list.
	task automatic owe_seg(input segment_t s);
		seg_expect.insert(seg_expect.size(), s);
	endtask

	// Work out every segment one accepted character causes and advance the shadow state.
	task automatic predict_segments(input logic [6:0] code, input logic last);
		logic [6:0] val;
		logic       bad;
		int         sum;
		if (!msg_open) begin
			owe_seg(make_seg(cbe_pkg::KIND_QUIET, 13'd0, quiet_len, 1'b0, 1'b0));
			owe_seg(make_seg(cbe_pkg::KIND_START,
				{2'b00, SYM_TABLE[cbe_pkg::START_B_VALUE]},
				cbe_pkg::CHAR_MODULES, 1'b0, 1'b0));
			msg_open = 1'b1;
		end
		// Control codes fall back to space, value zero, in pattern and checksum alike.
		if (code < cbe_pkg::SET_B_OFFSET) begin
			val = 7'd0;
			bad = 1'b1;
		end else begin
			val = code - cbe_pkg::SET_B_OFFSET;
			bad = 1'b0;
		end
		owe_seg(make_seg(cbe_pkg::KIND_DATA, {2'b00, SYM_TABLE[val]},
			cbe_pkg::CHAR_MODULES, bad, !last));
		sum      = int'(csum_acc) + int'(val) * int'(char_pos);
		csum_acc = 7'(sum % int'(cbe_pkg::CHECK_MOD));
		char_pos = 7'((int'(char_pos) + 1) % int'(cbe_pkg::CHECK_MOD));
		cur_msg_len++;
		if (last) begin
			owe_seg(make_seg(cbe_pkg::KIND_CSUM, {2'b00, SYM_TABLE[csum_acc]},
				cbe_pkg::CHAR_MODULES, 1'b0, 1'b0));
			owe_seg(make_seg(cbe_pkg::KIND_STOP, cbe_pkg::STOP_PATTERN,
				cbe_pkg::STOP_MODULES, 1'b0, 1'b0));
			owe_seg(make_seg(cbe_pkg::KIND_QUIET, 13'd0, quiet_len, 1'b0, 1'b1));
			msg_open = 1'b0;
			csum_acc = 7'd1;
			char_pos = 7'd1;
			msgs_done++;
			if (cur_msg_len > longest_msg)
				longest_msg = cur_msg_len;
			cur_msg_len = 0;
		end
	endtask

	// Driver: offer queued characters in bursts, with random gaps when enabled.
	int burst_left = 0;
	int gap_left   = 0;
	always @(posedge clk) begin
		char_beat_t nxt;
		if (arst_n) begin
			if (char_valid && msg_in.ready) begin
				predict_segments(char_code_q, char_last_q);
				chars_sent++;
				if (char_code_q < cbe_pkg::SET_B_OFFSET)
					bad_sent++;
			end
			// Hold the beat while the block pushes back; otherwise pick the next move.
			if (!char_valid || msg_in.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					char_valid <= 1'b0;
				end else if (char_queue.size() != 0) begin
					nxt = char_queue.pop_front();
					char_valid  <= 1'b1;
					char_code_q <= nxt.code;
					char_last_q <= nxt.last;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						gap_left   = sender_gaps ? $urandom_range(1, 9) : 0;
					end
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each segment beat against the oldest expectation and pace ready.
	logic [7:0] ready_bits  = 8'hFF;
	int         pattern_age = 0;
	always @(posedge clk) begin
		segment_t want;
		if (arst_n) begin
			if (seg_out.valid && seg_ready) begin
				if (seg_expect.size() == 0) begin
					report_mismatch("unexpected segment, kind", seg_out.segment_kind, 0);
				end else begin
					want = seg_expect.pop_front();
					if (seg_out.segment_kind !== want.kind)
						report_mismatch("segment_kind", seg_out.segment_kind, want.kind);
					if (seg_out.module_pattern !== want.pattern)
						report_mismatch("module_pattern", seg_out.module_pattern, want.pattern);
					if (seg_out.module_count !== want.count)
						report_mismatch("module_count", seg_out.module_count, want.count);
					if (seg_out.bad_char !== want.bad)
						report_mismatch("bad_char", seg_out.bad_char, want.bad);
					if (seg_out.run_end !== want.run_end)
						report_mismatch("run_end", seg_out.run_end, want.run_end);
				end
				segs_checked++;
			end
			if (rx_stalls) begin
				// Walk a rotating stall pattern and swap it now and then; bit 0 stays
				// set on reload so no stall outlasts one turn of the pattern.
				if (pattern_age == 0) begin
					ready_bits  = 8'($urandom_range(0, 255)) | 8'h01;
					pattern_age = $urandom_range(8, 48);
				end else begin
					pattern_age--;
				end
				seg_ready  <= ready_bits[0];
				ready_bits = {ready_bits[0], ready_bits[7:1]};
			end else begin
				seg_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if no channel moves a beat for too long.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_valid && msg_in.ready) || (seg_out.valid && seg_ready) ||
				(cfg_valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("[%0t] no beat for %0d cycles, %0d segments still owed",
					$realtime, HANG_LIMIT, seg_expect.size());
				$display("code128b_symbol_encoder_top regression: fail");
				$finish;
			end
		end
	end

	task automatic push_char(input logic [6:0] code, input logic last);
		char_beat_t b;
		b.code = code;
		b.last = last;
		char_queue.insert(char_queue.size(), b);
	endtask

	// Block the caller until every queued character is taken and every owed segment has come.
	task automatic wait_drained();
		@(posedge clk);
		while (char_queue.size() != 0 || char_valid || seg_expect.size() != 0)
			@(posedge clk);
	endtask

	// Write the quiet-zone register; only called while the block is idle.
	task automatic write_quiet(input logic [7:0] v);
		@(posedge clk);
		cfg_valid   <= 1'b1;
		cfg_quiet_q <= v;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		quiet_len = v;
		cfg_writes++;
	endtask

	// Queue one well-formed message of random content; roughly one character in eight
	// is a control code that must be flagged.
	task automatic queue_random_message(input int len);
		logic [6:0] code;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0)
				code = 7'($urandom_range(0, 31));
			else
				code = 7'($urandom_range(32, 127));
			push_char(code, i == len - 1);
		end
	endtask

	task automatic queue_random_messages(input int total);
		int left;
		int len;
		left = total;
		while (left > 0) begin
			len = $urandom_range(1, 8);
			if (len > left)
				len = left;
			queue_random_message(len);
			left -= len;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset quiet width, no pacing. Boundary characters, control codes
		// replaced by space, and a short multi-character word.
		push_char(7'd32, 1'b1);
		push_char(7'd127, 1'b1);
		push_char(7'd0, 1'b1);
		push_char(7'd31, 1'b0);
		push_char(7'd64, 1'b0);
		push_char(7'd127, 1'b1);
		push_char(7'd67, 1'b0);
		push_char(7'd111, 1'b0);
		push_char(7'd100, 1'b0);
		push_char(7'd101, 1'b1);
		wait_drained();

		// Zero quiet zone: the quiet segments still appear, with no modules.
		write_quiet(8'd0);
		rx_stalls = 1'b1;
		push_char(7'd85, 1'b0);
		push_char(7'd42, 1'b1);
		push_char(7'd1, 1'b1);
		wait_drained();

		// Widest quiet zone, both sides idling.
		write_quiet(8'd255);
		sender_gaps = 1'b1;
		push_char(7'd126, 1'b0);
		push_char(7'd33, 1'b0);
		push_char(7'd16, 1'b1);
		wait_drained();

		// Random short messages, sender bursts against a receiver that never stalls.
		write_quiet(8'($urandom_range(1, 40)));
		rx_stalls = 1'b0;
		queue_random_messages(20);
		wait_drained();

		// One message well past 103 characters so the position wraps.
		write_quiet(8'($urandom_range(0, 255)));
		rx_stalls = 1'b1;
		queue_random_message(110);
		wait_drained();

		// Back-to-back characters into a stalling receiver, then restore the reset width.
		write_quiet(8'($urandom_range(0, 255)));
		sender_gaps = 1'b0;
		queue_random_messages(30);
		wait_drained();
		write_quiet(cbe_pkg::QUIET_RESET);
		sender_gaps = 1'b1;
		queue_random_messages(6);
		wait_drained();

		// Keep watching for stray segments before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (seg_expect.size() != 0)
			report_mismatch("segments never delivered", 0, seg_expect.size());

		$display("covered %0d characters (%0d control codes) in %0d messages, longest %0d",
			chars_sent, bad_sent, msgs_done, longest_msg);
		$display("checked %0d segments across %0d quiet-zone writes, %0d mismatches",
			segs_checked, cfg_writes, error_count);
		if (error_count == 0)
			$display("code128b_symbol_encoder_top regression: pass");
		else
			$display("code128b_symbol_encoder_top regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/cbe_pkg.sv
rtl/core/cbe_ifs.sv
rtl/core/cbe_front.sv
rtl/core/cbe_queue.sv
rtl/core/cbe_back.sv
rtl/core/code128b_symbol_encoder_top.sv
rtl/core/cbe_checker.sv
bench/code128b_symbol_encoder_top_tb.sv
